// File: design/assert_macros.svh
// assertion helpers, clocked on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pss_pkg.sv
package pss_pkg;

  // field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int CM_W       = 10;
  localparam int HZ_W       = 12;
  localparam int ECHO_W     = 20;
  localparam int DIST_W     = 16;
  localparam int ZONE_W     = 2;
  localparam int DWELL_W    = 5;
  localparam int BEEP_W     = 8;

  // distance = echo_us * 1114 >> 16 (about 0.034 / 2 cm per us)
  localparam int MUL_W      = 11;
  localparam int PROD_W     = ECHO_W + MUL_W;
  localparam int DIST_SHIFT = 16;
  localparam logic [MUL_W-1:0] DIST_MUL = 11'd1114;

  // dwell divider: quotient always below 2**DIV_STEPS
  localparam int DIV_STEPS = 4;
  localparam int NUM_W     = CM_W + DIV_STEPS;
  localparam int CNT_W     = 2;

  localparam logic [HZ_W-1:0]    FAR_STEP_HZ  = 12'd5;
  localparam logic [HZ_W-1:0]    NEAR_STEP_HZ = 12'd10;
  localparam logic [DWELL_W-1:0] FAR_BASE     = 5'd5;
  localparam logic [DWELL_W-1:0] NEAR_BASE    = 5'd3;
  localparam logic [BEEP_W-1:0]  URGENT_ON    = 8'd100;
  localparam logic [BEEP_W-1:0]  URGENT_ALL   = 8'd150;

  // register reset values
  localparam logic [CM_W-1:0] SILENT_CM_RST    = 10'd100;
  localparam logic [CM_W-1:0] FAR_CM_RST       = 10'd50;
  localparam logic [CM_W-1:0] NEAR_CM_RST      = 10'd20;
  localparam logic [HZ_W-1:0] FAR_LOW_HZ_RST   = 12'd300;
  localparam logic [HZ_W-1:0] FAR_HIGH_HZ_RST  = 12'd600;
  localparam logic [HZ_W-1:0] NEAR_LOW_HZ_RST  = 12'd400;
  localparam logic [HZ_W-1:0] NEAR_HIGH_HZ_RST = 12'd900;
  localparam logic [HZ_W-1:0] URGENT_HZ_RST    = 12'd1000;

  localparam logic ACT_ECHO = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SILENT_CM,
    REG_FAR_CM,
    REG_NEAR_CM,
    REG_FAR_LOW_HZ,
    REG_FAR_HIGH_HZ,
    REG_NEAR_LOW_HZ,
    REG_NEAR_HIGH_HZ,
    REG_URGENT_HZ
  } cfg_reg_t;

  typedef enum logic [ZONE_W-1:0] {
    ZN_CLEAR,
    ZN_FAR,
    ZN_NEAR,
    ZN_CRIT
  } zone_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ECHO,
    S_TICK,
    S_START,
    S_DIV,
    S_OUT
  } seq_state_t;

endpackage

// File: design/pss_meas_if.sv
interface pss_meas_if import pss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [ECHO_W-1:0] echo_us;

  modport source (output valid, action, echo_us, input ready);
  modport sink   (input valid, action, echo_us, output ready);
endinterface

// File: design/pss_status_if.sv
interface pss_status_if import pss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_cm;
  logic [ZONE_W-1:0] zone;
  logic              tone_on;
  logic [HZ_W-1:0]   tone_hz;
  logic              busy_res;

  modport source (output valid, distance_cm, zone, tone_on, tone_hz, busy_res, input ready);
  modport sink   (input valid, distance_cm, zone, tone_on, tone_hz, busy_res, output ready);
endinterface

// File: design/proximity_siren_sequencer.sv
// channel   dir  payload                                       role
// meas      in   action, echo_us                               echo (0) or 1 ms tick (1)
// status    out  distance_cm, zone, tone_on, tone_hz, busy_res one per meas transaction
// cfg_*     in   cfg_we, cfg_index, cfg_data                   register writes, no wait
//
// states per meas accept; out holds while the status register is still full:
// tick: tick, out; the sweep step is done in the tick state
// echo: echo, out when latched behind a playing pattern; echo, start, out when
// a clear or critical pattern starts, plus the 4-step shared divider for far/near
// a tick ending a pattern and starting the pending echo runs start/div the same way
// meas is taken only in the idle state; status is a register, so a new
// transaction is accepted while the previous result is still waiting
// rst is synchronous; the block is ready in the same cycle that rst falls
`include "assert_macros.svh"

module proximity_siren_sequencer import pss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pss_meas_if.sink              meas,
  pss_status_if.source          status
);

  // configuration registers
  logic [CM_W-1:0] silent_cm, far_cm, near_cm;
  logic [HZ_W-1:0] far_low_hz, far_high_hz, near_low_hz, near_high_hz, urgent_hz;

  // pattern state
  seq_state_t         state, state_next;
  zone_t              cur_zone;
  logic [DIST_W-1:0]  cur_distance;
  logic [HZ_W-1:0]    cur_freq;
  logic               sweep_down;
  logic [DWELL_W-1:0] dwell_ticks;
  logic [DWELL_W-1:0] dwell_len;
  logic [BEEP_W-1:0]  beep_ticks;
  logic               playing;
  logic               pending_valid;
  logic [DIST_W-1:0]  pending_distance;

  // datapath registers
  logic [PROD_W-1:0]    prod;
  logic [DIST_W-1:0]    start_d;
  logic [NUM_W-1:0]     rem;
  logic [NUM_W-1:0]     dsh;
  logic [DIV_STEPS-1:0] quo;
  logic [CNT_W-1:0]     div_cnt;

  // result register
  logic              out_valid;
  logic [DIST_W-1:0] out_distance;
  zone_t             out_zone;
  logic              out_tone_on;
  logic [HZ_W-1:0]   out_tone_hz;
  logic              out_busy;

  // config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      silent_cm    <= SILENT_CM_RST;
      far_cm       <= FAR_CM_RST;
      near_cm      <= NEAR_CM_RST;
      far_low_hz   <= FAR_LOW_HZ_RST;
      far_high_hz  <= FAR_HIGH_HZ_RST;
      near_low_hz  <= NEAR_LOW_HZ_RST;
      near_high_hz <= NEAR_HIGH_HZ_RST;
      urgent_hz    <= URGENT_HZ_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SILENT_CM:    silent_cm    <= cfg_data[CM_W-1:0];
        REG_FAR_CM:       far_cm       <= cfg_data[CM_W-1:0];
        REG_NEAR_CM:      near_cm      <= cfg_data[CM_W-1:0];
        REG_FAR_LOW_HZ:   far_low_hz   <= cfg_data;
        REG_FAR_HIGH_HZ:  far_high_hz  <= cfg_data;
        REG_NEAR_LOW_HZ:  near_low_hz  <= cfg_data;
        REG_NEAR_HIGH_HZ: near_high_hz <= cfg_data;
        REG_URGENT_HZ:    urgent_hz    <= cfg_data;
        default: ;
      endcase
    end
  end

  // measured distance; 20-bit echo * 1114 >> 16 stays below 2**15, no clamp needed
  logic [DIST_W-1:0] meas_d;
  assign meas_d = {1'b0, prod[PROD_W-1:DIST_SHIFT]};

  // sweep bounds of the pattern in force
  logic [HZ_W-1:0] lo_hz, hi_hz, step_hz;
  always_comb begin
    lo_hz   = (cur_zone == ZN_FAR) ? far_low_hz  : near_low_hz;
    hi_hz   = (cur_zone == ZN_FAR) ? far_high_hz : near_high_hz;
    step_hz = (cur_zone == ZN_FAR) ? FAR_STEP_HZ : NEAR_STEP_HZ;
  end

  // pattern start: zone pick and dwell numerator / divisor
  zone_t           new_zone;
  logic [CM_W-1:0] lo_cm, hi_cm, span_cm, xs;
  logic [DIST_W-1:0] x_full;
  logic [NUM_W-1:0]  num;
  logic [HZ_W-1:0]   new_lo_hz, new_hi_hz;
  always_comb begin
    if (start_d > {{(DIST_W-CM_W){1'b0}}, silent_cm}) begin
      new_zone = ZN_CLEAR;
    end else if (start_d > {{(DIST_W-CM_W){1'b0}}, far_cm}) begin
      new_zone = ZN_FAR;
    end else if (start_d > {{(DIST_W-CM_W){1'b0}}, near_cm}) begin
      new_zone = ZN_NEAR;
    end else begin
      new_zone = ZN_CRIT;
    end
    lo_cm   = (new_zone == ZN_FAR) ? far_cm    : near_cm;
    hi_cm   = (new_zone == ZN_FAR) ? silent_cm : far_cm;
    span_cm = hi_cm - lo_cm;
    // inside the zone d - lo never exceeds hi - lo, so 10 bits hold it
    x_full  = start_d - {{(DIST_W-CM_W){1'b0}}, lo_cm};
    xs      = x_full[CM_W-1:0];
    // times 15 for far, times 5 for near
    if (new_zone == ZN_FAR) begin
      num = {xs, {DIV_STEPS{1'b0}}} - {{DIV_STEPS{1'b0}}, xs};
    end else begin
      num = {2'b00, xs, 2'b00} + {{DIV_STEPS{1'b0}}, xs};
    end
    new_lo_hz = (new_zone == ZN_FAR) ? far_low_hz  : near_low_hz;
    new_hi_hz = (new_zone == ZN_FAR) ? far_high_hz : near_high_hz;
  end

  // shared divider step: one compare and subtract per cycle
  logic                 div_ge;
  logic [DIV_STEPS-1:0] quo_n;
  logic [DWELL_W-1:0]   dwell_base;
  assign div_ge     = (rem >= dsh);
  assign quo_n      = {quo[DIV_STEPS-2:0], div_ge};
  assign dwell_base = (cur_zone == ZN_FAR) ? FAR_BASE : NEAR_BASE;

  // tick step
  logic [BEEP_W-1:0]  beep_n;
  logic [DWELL_W-1:0] dt_n;
  logic [HZ_W:0]      up_sum;
  logic [HZ_W-1:0]    down_diff;
  logic               dwell_due;
  logic               tick_end;
  always_comb begin
    beep_n    = beep_ticks + 1'b1;
    dt_n      = dwell_ticks + 1'b1;
    up_sum    = {1'b0, cur_freq} + {1'b0, step_hz};
    down_diff = cur_freq - step_hz;
    dwell_due = playing && (cur_zone != ZN_CRIT) && (dt_n >= dwell_len);
    tick_end  = 1'b0;
    if (playing) begin
      if (cur_zone == ZN_CRIT) begin
        tick_end = (beep_n >= URGENT_ALL);
      end else if (dwell_due) begin
        if (!sweep_down) begin
          // top reached with reversed bounds ends at once
          tick_end = (up_sum > {1'b0, hi_hz}) && (hi_hz < lo_hz);
        end else begin
          tick_end = !((cur_freq >= step_hz) && (down_diff >= lo_hz));
        end
      end
    end
  end

  // tone seen by the result
  logic tone_now;
  assign tone_now = playing &&
                    ((cur_zone == ZN_FAR) || (cur_zone == ZN_NEAR) ||
                     ((cur_zone == ZN_CRIT) && (beep_ticks < URGENT_ON)));

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (meas.valid) begin
          state_next = (meas.action == ACT_TICK) ? S_TICK : S_ECHO;
        end
      end
      S_ECHO:  state_next = playing ? S_OUT : S_START;
      S_TICK:  state_next = (tick_end && pending_valid) ? S_START : S_OUT;
      S_START: begin
        state_next = ((new_zone == ZN_FAR) || (new_zone == ZN_NEAR)) ? S_DIV : S_OUT;
      end
      S_DIV:   state_next = (div_cnt == '0) ? S_OUT : S_DIV;
      S_OUT: begin
        if (!out_valid || status.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  logic out_load;
  always_comb begin
    meas.ready = (state == S_IDLE) && !rst;
    out_load   = (state == S_OUT) && (!out_valid || status.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pattern state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_zone         <= ZN_CLEAR;
      cur_distance     <= '0;
      cur_freq         <= '0;
      sweep_down       <= 1'b0;
      dwell_ticks      <= '0;
      dwell_len        <= '0;
      beep_ticks       <= '0;
      playing          <= 1'b0;
      pending_valid    <= 1'b0;
      pending_distance <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          prod <= {{MUL_W{1'b0}}, meas.echo_us} * {{ECHO_W{1'b0}}, DIST_MUL};
        end
        S_ECHO: begin
          // echo during a pattern waits for the pattern to end
          if (playing) begin
            pending_valid    <= 1'b1;
            pending_distance <= meas_d;
          end else begin
            start_d <= meas_d;
          end
        end
        S_TICK: begin
          if (playing) begin
            if (cur_zone == ZN_CRIT) begin
              beep_ticks <= beep_n;
            end else if (dwell_due) begin
              dwell_ticks <= '0;
              if (!sweep_down) begin
                if (up_sum <= {1'b0, hi_hz}) begin
                  cur_freq <= up_sum[HZ_W-1:0];
                end else begin
                  // down half always starts at the high bound
                  sweep_down <= 1'b1;
                  cur_freq   <= hi_hz;
                end
              end else if (!tick_end) begin
                cur_freq <= down_diff;
              end
            end else begin
              dwell_ticks <= dt_n;
            end
            if (tick_end) begin
              if (pending_valid) begin
                pending_valid <= 1'b0;
                start_d       <= pending_distance;
              end else begin
                playing  <= 1'b0;
                cur_freq <= '0;
              end
            end
          end
        end
        S_START: begin
          cur_distance <= start_d;
          cur_zone     <= new_zone;
          dwell_ticks  <= '0;
          beep_ticks   <= '0;
          sweep_down   <= 1'b0;
          dwell_len    <= '0;
          case (new_zone)
            ZN_CLEAR: begin
              playing  <= 1'b0;
              cur_freq <= '0;
            end
            ZN_CRIT: begin
              playing  <= 1'b1;
              cur_freq <= urgent_hz;
            end
            default: begin
              if (new_lo_hz > new_hi_hz) begin
                playing  <= 1'b0;
                cur_freq <= '0;
              end else begin
                playing  <= 1'b1;
                cur_freq <= new_lo_hz;
              end
            end
          endcase
          rem     <= num;
          dsh     <= {{(NUM_W-CM_W-DIV_STEPS+1){1'b0}}, span_cm, {(DIV_STEPS-1){1'b0}}};
          quo     <= '0;
          div_cnt <= CNT_W'(DIV_STEPS - 1);
        end
        S_DIV: begin
          if (div_ge) begin
            rem <= rem - dsh;
          end
          quo     <= quo_n;
          dsh     <= dsh >> 1;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            dwell_len <= dwell_base + {{(DWELL_W-DIV_STEPS){1'b0}}, quo_n};
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_distance <= cur_distance;
      out_zone     <= cur_zone;
      out_tone_on  <= tone_now;
      out_tone_hz  <= tone_now ? cur_freq : '0;
      out_busy     <= playing;
    end
  end

  assign status.valid       = out_valid;
  assign status.distance_cm = out_distance;
  assign status.zone        = out_zone;
  assign status.tone_on     = out_tone_on;
  assign status.tone_hz     = out_tone_hz;
  assign status.busy_res    = out_busy;

  // checks
  logic idle_play, idle_sweep, idle_crit, dwell_ok;
  assign idle_play  = (state == S_IDLE) && playing;
  assign idle_sweep = idle_play && ((cur_zone == ZN_FAR) || (cur_zone == ZN_NEAR));
  assign idle_crit  = idle_play && (cur_zone == ZN_CRIT);
  assign dwell_ok   = (dwell_len >= NEAR_BASE) && (dwell_len <= 5'd20);

  `PSS_ASSERT_IMP(a_play_not_clear, playing, cur_zone != ZN_CLEAR, "pattern plays in clear zone")
  `PSS_ASSERT_IMP(a_dwell_range, idle_sweep, dwell_ok, "dwell out of range")
  `PSS_ASSERT_IMP(a_beep_range, idle_crit, beep_ticks < URGENT_ALL, "beep count past end")
  `PSS_ASSERT_NXT(a_div_exit, state == S_DIV, (state == S_DIV) || (state == S_OUT), "divider left early")

endmodule
